FILE: rtl/sspq_pkg.sv
package sspq_pkg;

  // Default sizes of the queue.
  localparam int DEF_CAPACITY      = 16;
  localparam int DEF_PRIORITY_BITS = 8;
  localparam int DEF_TAG_BITS      = 16;

  // Result status codes.
  localparam int STATUS_W = 2;
  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SERVED   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  // Request codes.
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_INS_CMP,
    S_INS_PUT,
    S_REM_OUT
  } state_t;

  // Control group from the sequencer to the entry ring.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic pop;
  } ring_ctl_t;

endpackage

FILE: rtl/sspq_ring.sv
module sspq_ring #(
  parameter int CAPACITY = sspq_pkg::DEF_CAPACITY,
  parameter int ENTRY_W  = sspq_pkg::DEF_TAG_BITS + sspq_pkg::DEF_PRIORITY_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sspq_pkg::ring_ctl_t           ctl,
  input  logic [$clog2(CAPACITY)-1:0]   rd_idx,
  input  logic [$clog2(CAPACITY)-1:0]   wr_idx,
  input  logic [ENTRY_W-1:0]            wr_data,
  output logic [ENTRY_W-1:0]            rd_data
);
  import sspq_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam logic [IDX_W:0]   CAP_WIDE = (IDX_W+1)'(CAPACITY);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

  logic [ENTRY_W-1:0] mem [CAPACITY];
  logic [IDX_W-1:0]   head;
  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   wr_addr;
  logic [IDX_W:0]     rd_sum;
  logic [IDX_W:0]     wr_sum;

  // Logical positions are offsets from the head; wrap them into the ring.
  always_comb begin
    rd_sum = {1'b0, head} + {1'b0, rd_idx};
    wr_sum = {1'b0, head} + {1'b0, wr_idx};
    if (rd_sum >= CAP_WIDE) begin
      rd_sum = rd_sum - CAP_WIDE;
    end
    if (wr_sum >= CAP_WIDE) begin
      wr_sum = wr_sum - CAP_WIDE;
    end
    rd_addr = rd_sum[IDX_W-1:0];
    wr_addr = wr_sum[IDX_W-1:0];
  end

  // Removing the head entry just advances the head pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
    end else if (ctl.pop) begin
      head <= (head == LAST_IDX) ? '0 : head + 1'b1;
    end
  end

  // Entry memory with one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/stable_sorted_priority_queue_core.sv
// Stable sorted priority queue.
// A transaction is accepted on a rising edge with start high and busy low.
// req_type selects insert (entry_tag, entry_priority) or remove of the head.
// Lower priority values leave first; equal priorities leave in arrival order.
// Every transaction yields exactly one result: done is high for one cycle with
// status, served_tag and served_priority; the served fields are zero unless
// the status is served. The receiver cannot stall; results are never held.
// Entries live in a ring memory with a registered read. A remove reads the
// head at acceptance, returns it in S_REM_OUT and advances the head pointer.
// An insert into a non-empty queue walks from the tail toward the head,
// reading one entry and writing it one place back per cycle until the new
// entry's place is found. An insert into an empty queue is written at once,
// and it, the full result and the empty result finish in the idle state
// without a walk. One transaction is in flight at a time; busy is low again
// in the cycle done is shown, so the next transaction can be taken then.
// Synchronous reset empties the queue; memory contents are not cleared and
// are never read before they are written.
module stable_sorted_priority_queue_core #(
  parameter int CAPACITY      = sspq_pkg::DEF_CAPACITY,
  parameter int PRIORITY_BITS = sspq_pkg::DEF_PRIORITY_BITS,
  parameter int TAG_BITS      = sspq_pkg::DEF_TAG_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          req_type,
  input  logic [TAG_BITS-1:0]           entry_tag,
  input  logic [PRIORITY_BITS-1:0]      entry_priority,
  output logic                          done,
  output logic [sspq_pkg::STATUS_W-1:0] status,
  output logic [TAG_BITS-1:0]           served_tag,
  output logic [PRIORITY_BITS-1:0]      served_priority
);
  import sspq_pkg::*;

  localparam int IDX_W   = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int ENTRY_W = TAG_BITS + PRIORITY_BITS;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  state_t state;
  state_t state_next;

  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;
  logic [IDX_W-1:0]         cursor;
  logic [IDX_W-1:0]         cursor_next;
  logic [TAG_BITS-1:0]      tag_q;
  logic [PRIORITY_BITS-1:0] prio_q;

  ring_ctl_t          ctl;
  logic [IDX_W-1:0]   rd_idx;
  logic [IDX_W-1:0]   wr_idx;
  logic [ENTRY_W-1:0] wr_data;
  logic [ENTRY_W-1:0] rd_data;

  logic                     accept;
  logic                     finish;
  logic [STATUS_W-1:0]      res_status;
  logic [TAG_BITS-1:0]      res_tag;
  logic [PRIORITY_BITS-1:0] res_prio;
  logic [PRIORITY_BITS-1:0] rd_prio;
  logic [TAG_BITS-1:0]      rd_tag;
  logic                     rd_later;

  assign accept   = start && !busy;
  assign busy     = (state != S_IDLE);
  assign rd_prio  = rd_data[PRIORITY_BITS-1:0];
  assign rd_tag   = rd_data[ENTRY_W-1 -: TAG_BITS];
  // The stored entry moves back only if it is served strictly later.
  assign rd_later = (rd_prio > prio_q);

  sspq_ring #(
    .CAPACITY (CAPACITY),
    .ENTRY_W  (ENTRY_W)
  ) u_ring (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .rd_idx  (rd_idx),
    .wr_idx  (wr_idx),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (req_type == REQ_INSERT) begin
            if (count != CAP_CNT && count != '0) begin
              state_next = S_INS_CMP;
            end
          end else if (count != '0) begin
            state_next = S_REM_OUT;
          end
        end
      end
      S_INS_CMP: begin
        if (!rd_later) begin
          state_next = S_IDLE;
        end else if (cursor == '0) begin
          state_next = S_INS_PUT;
        end
      end
      S_INS_PUT: state_next = S_IDLE;
      S_REM_OUT: state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Memory control, count and cursor updates, and result values.
  always_comb begin
    ctl         = '0;
    rd_idx      = '0;
    wr_idx      = '0;
    wr_data     = {tag_q, prio_q};
    count_next  = count;
    cursor_next = cursor;
    finish      = 1'b0;
    res_status  = ST_INSERTED;
    res_tag     = '0;
    res_prio    = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (req_type == REQ_INSERT) begin
            if (count == CAP_CNT) begin
              finish     = 1'b1;
              res_status = ST_FULL;
            end else if (count == '0) begin
              ctl.wr_en  = 1'b1;
              wr_data    = {entry_tag, entry_priority};
              count_next = count + 1'b1;
              finish     = 1'b1;
              res_status = ST_INSERTED;
            end else begin
              // Start the walk at the tail entry.
              ctl.rd_en   = 1'b1;
              rd_idx      = IDX_W'(count - 1'b1);
              cursor_next = IDX_W'(count - 1'b1);
            end
          end else if (count == '0) begin
            finish     = 1'b1;
            res_status = ST_EMPTY;
          end else begin
            ctl.rd_en = 1'b1;
            rd_idx    = '0;
          end
        end
      end
      S_INS_CMP: begin
        ctl.wr_en = 1'b1;
        wr_idx    = cursor + 1'b1;
        if (rd_later) begin
          // Shift this entry one place back and look at the one before it.
          wr_data = rd_data;
          if (cursor != '0) begin
            ctl.rd_en   = 1'b1;
            rd_idx      = cursor - 1'b1;
            cursor_next = cursor - 1'b1;
          end
        end else begin
          count_next = count + 1'b1;
          finish     = 1'b1;
          res_status = ST_INSERTED;
        end
      end
      S_INS_PUT: begin
        ctl.wr_en  = 1'b1;
        wr_idx     = '0;
        count_next = count + 1'b1;
        finish     = 1'b1;
        res_status = ST_INSERTED;
      end
      S_REM_OUT: begin
        ctl.pop    = 1'b1;
        count_next = count - 1'b1;
        finish     = 1'b1;
        res_status = ST_SERVED;
        res_tag    = rd_tag;
        res_prio   = rd_prio;
      end
      default: begin
        finish = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= finish;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cursor <= cursor_next;
    if (accept) begin
      tag_q  <= entry_tag;
      prio_q <= entry_priority;
    end
    if (finish) begin
      status          <= res_status;
      served_tag      <= res_tag;
      served_priority <= res_prio;
    end
  end

  // The entry count never exceeds the capacity.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_CNT)
    else $error("entry count above capacity");

  // A result is only shown once the sequencer is idle again.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  // An insert into a full queue is refused on the next cycle.
  a_full_refused: assert property (@(posedge clk) disable iff (rst)
    (accept && req_type == REQ_INSERT && count == CAP_CNT) |=>
      (done && status == ST_FULL))
    else $error("insert into full queue not refused");

  // A served result always removes exactly one entry.
  a_served_count: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_SERVED) |-> (count == $past(count) - 1'b1))
    else $error("served result without count decrement");

endmodule

FILE: tb/sspq_checker.sv
module sspq_checker #(
  parameter int CAPACITY      = sspq_pkg::DEF_CAPACITY,
  parameter int PRIORITY_BITS = sspq_pkg::DEF_PRIORITY_BITS,
  parameter int TAG_BITS      = sspq_pkg::DEF_TAG_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic                          req_type,
  input  logic [TAG_BITS-1:0]           entry_tag,
  input  logic [PRIORITY_BITS-1:0]      entry_priority,
  input  logic                          done,
  input  logic [sspq_pkg::STATUS_W-1:0] status,
  input  logic [TAG_BITS-1:0]           served_tag,
  input  logic [PRIORITY_BITS-1:0]      served_priority,
  output int                            mismatches,
  output int                            outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import sspq_pkg::*;

  typedef struct {
    logic [STATUS_W-1:0]      status;
    logic [TAG_BITS-1:0]      tag;
    logic [PRIORITY_BITS-1:0] prio;
  } outcome_t;

  // Shadow copy of the queue, head at index 0, sorted by ascending priority.
  logic [TAG_BITS-1:0]      queued_tag  [CAPACITY];
  logic [PRIORITY_BITS-1:0] queued_prio [CAPACITY];
  int                       queued_count;

  // Results still owed by the block, oldest first.
  outcome_t expected_outcomes [$];

  // Apply one transaction to the shadow queue and work out its result.
  task automatic serve_or_enqueue(input logic req, input logic [TAG_BITS-1:0] tag,
                                  input logic [PRIORITY_BITS-1:0] prio,
                                  output outcome_t outcome);
    int slot;
    outcome.status = ST_INSERTED;
    outcome.tag    = '0;
    outcome.prio   = '0;
    if (req == REQ_INSERT) begin
      if (queued_count >= CAPACITY) begin
        outcome.status = ST_FULL;
      end else begin
        // Walk back from the tail past every strictly larger priority, so ties
        // stay in arrival order.
        slot = queued_count;
        while (slot > 0 && queued_prio[slot-1] > prio) begin
          queued_tag[slot]  = queued_tag[slot-1];
          queued_prio[slot] = queued_prio[slot-1];
          slot--;
        end
        queued_tag[slot]  = tag;
        queued_prio[slot] = prio;
        queued_count++;
      end
    end else if (queued_count == 0) begin
      outcome.status = ST_EMPTY;
    end else begin
      outcome.status = ST_SERVED;
      outcome.tag    = queued_tag[0];
      outcome.prio   = queued_prio[0];
      for (slot = 1; slot < queued_count; slot++) begin
        queued_tag[slot-1]  = queued_tag[slot];
        queued_prio[slot-1] = queued_prio[slot];
      end
      queued_count--;
    end
  endtask

  // Results are checked before the transaction of the same edge is predicted,
  // since a result always belongs to an earlier transaction.
  always @(posedge clk) begin : track
    outcome_t want;
    if (rst) begin
      queued_count = 0;
      mismatches   = 0;
      expected_outcomes.delete();
    end else begin
      if (done) begin
        if (expected_outcomes.size() == 0) begin
          $error("result with no transaction outstanding: status %0d", status);
          mismatches++;
        end else begin
          want = expected_outcomes.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            mismatches++;
          end
          if (served_tag !== want.tag) begin
            $error("served_tag: expected %0h, actual %0h", want.tag, served_tag);
            mismatches++;
          end
          if (served_priority !== want.prio) begin
            $error("served_priority: expected %0d, actual %0d", want.prio,
                   served_priority);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        serve_or_enqueue(req_type, entry_tag, entry_priority, want);
        expected_outcomes.push_back(want);
      end
    end
    outstanding = expected_outcomes.size();
  end

endmodule

FILE: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sspq_pkg::*;

  localparam int CAPACITY      = DEF_CAPACITY;
  localparam int PRIORITY_BITS = DEF_PRIORITY_BITS;
  localparam int TAG_BITS      = DEF_TAG_BITS;
  localparam int RANDOM_ITEMS  = 430;
  localparam int QUIET_ITEMS   = 80;
  localparam int STALL_LIMIT   = 2000;

  // Priorities used to fill the queue: extremes, ties at head, middle and tail.
  localparam logic [PRIORITY_BITS-1:0] FILL_PRIO [16] = '{
    8'hFF, 8'h00, 8'd5, 8'd5, 8'd5, 8'h00, 8'hFF, 8'd128,
    8'd1, 8'd254, 8'd5, 8'd7, 8'd7, 8'd64, 8'd200, 8'd3
  };

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic                     req_type;
  logic [TAG_BITS-1:0]      entry_tag;
  logic [PRIORITY_BITS-1:0] entry_priority;
  logic                     done;
  logic [STATUS_W-1:0]      status;
  logic [TAG_BITS-1:0]      served_tag;
  logic [PRIORITY_BITS-1:0] served_priority;

  int mismatches;
  int outstanding;
  int stall_cycles;
  bit idling_on;

  stable_sorted_priority_queue_core #(
    .CAPACITY(CAPACITY), .PRIORITY_BITS(PRIORITY_BITS), .TAG_BITS(TAG_BITS)
  ) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req_type(req_type),
    .entry_tag(entry_tag), .entry_priority(entry_priority), .done(done),
    .status(status), .served_tag(served_tag), .served_priority(served_priority)
  );

  sspq_checker #(
    .CAPACITY(CAPACITY), .PRIORITY_BITS(PRIORITY_BITS), .TAG_BITS(TAG_BITS)
  ) checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req_type(req_type),
    .entry_tag(entry_tag), .entry_priority(entry_priority), .done(done),
    .status(status), .served_tag(served_tag), .served_priority(served_priority),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Drive one transaction from a falling edge and hold it until it is taken;
  // unless idling drops start, it stays high so a following one can go out back to back.
  task automatic issue_request(input logic req, input logic [TAG_BITS-1:0] tag,
                               input logic [PRIORITY_BITS-1:0] prio);
    start          = 1'b1;
    req_type       = req;
    entry_tag      = tag;
    entry_priority = prio;
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
  endtask

  // Stop sending until every outstanding result has come back.
  task automatic drain_results();
    start = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL stable_sorted_priority_queue_core");
      $finish;
    end
  end

  initial begin : stimulus
    int insert_pct;
    logic req;
    logic [PRIORITY_BITS-1:0] prio;
    rst            = 1'b1;
    start          = 1'b0;
    req_type       = REQ_INSERT;
    entry_tag      = '0;
    entry_priority = '0;
    idling_on      = 1'b1;
    insert_pct     = 50;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Remove from an empty queue, with the ignored fields set to all ones.
    issue_request(REQ_REMOVE, '1, '1);
    // Fill to capacity with ties and extreme tags and priorities.
    for (int i = 0; i < CAPACITY; i++) begin
      issue_request(REQ_INSERT, (i == 0) ? '1 : (i == 1) ? '0 : 16'hA5A0 + i[15:0],
                    FILL_PRIO[i[3:0]]);
    end
    // Insert into a full queue is refused.
    issue_request(REQ_INSERT, 16'h1234, '0);
    repeat (4) issue_request(REQ_REMOVE, TAG_BITS'($urandom), PRIORITY_BITS'($urandom));
    drain_results();

    // Random traffic in bursts that lean toward filling, toward emptying or to neither side.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 25 == 0) begin
        case ($urandom_range(0, 2))
          0: begin
            insert_pct = 85;
          end
          1: begin
            insert_pct = 50;
          end
          default: begin
            insert_pct = 15;
          end
        endcase
      end
      if (n == RANDOM_ITEMS / 2) begin
        drain_results();
      end
      idling_on = (n < RANDOM_ITEMS - QUIET_ITEMS);
      req  = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_REMOVE;
      // Narrow priorities half the time so ties are common.
      prio = $urandom_range(0, 1) ? PRIORITY_BITS'($urandom_range(0, 3))
                                  : PRIORITY_BITS'($urandom_range(0, 255));
      issue_request(req, TAG_BITS'($urandom), prio);
    end

    drain_results();
    repeat (CAPACITY + 4) @(negedge clk);
    if (mismatches == 0) begin
      $display("PASS stable_sorted_priority_queue_core");
    end else begin
      $display("FAIL stable_sorted_priority_queue_core");
    end
    $finish;
  end

endmodule
